### rtl/rmod_pkg.sv
package rmod_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_MODE    = 4'd0,
      CSR_SHAPE_MIX      = 4'd1,
      CSR_PITCH_OFFSET   = 4'd2,
      CSR_BASE_INCREMENT = 4'd3
   } csr_index_type;

   localparam int PITCH_W = 16;
   localparam int OFFSET_W = 14;
   localparam int MIX_W = 13;
   localparam int INC_W = 28;
   localparam int PHASE_W = 32;
   localparam int EXP_W = 32;
   localparam int SHIFT_W = 6;
   localparam int PITCH_U_W = 15;
   localparam int PITCH_FRAC_BITS = 11;
   localparam int MIX_FRAC_BITS = 12;
   localparam int STEP_SHIFT_TOP = 34;

   localparam logic [MIX_W-1:0] MIX_FULL = 13'd4096;
   localparam logic signed [PITCH_W:0] PITCH_LIMIT = 17'sd8192;
   localparam logic signed [PITCH_W:0] PITCH_FLOOR = -17'sd8192;
   localparam logic [INC_W-1:0] BASE_INC_RESET = 28'd39370533;

   localparam int Q30_BITS = 30;
   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_LN2 = 64'd744261118;
   localparam int SINE_TERMS = 8;
   localparam int EXP_TERMS = 12;

endpackage

### rtl/ring_modulator_with_oscillator_unit.sv
// Ring modulator with a built-in oscillator. Each item carries a carrier sample, an external
// modulator sample and a pitch control voltage, and yields one saturated output sample. The
// oscillator phase advances with every item in both modes. An accepted item passes through the
// pitch, step, phase, sine, mix1, mix2, wave, out and done states; the done state registers the
// result and returns to idle, but holds while an earlier result still waits on rsp_ready. One
// 29 by 33 bit multiplier is used four times per item (phase step, the two halves of the
// sine/saw crossfade and the output product), and the sequencer waits on each of the two
// registered table reads. A new item is accepted while an earlier result still waits on rsp_ready.
// Configuration writes are always taken and should only be made while the block is idle.
module ring_modulator_with_oscillator_unit #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int EXP_TABLE_BITS = 8,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_carrier_sample,
   input  logic signed [SAMPLE_WIDTH-1:0]        req_modulator_sample,
   input  logic signed [rmod_pkg::PITCH_W-1:0]   req_pitch_cv,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]        rsp_out_sample,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rmod_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rmod_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import rmod_pkg::*;

   localparam int FRAC_BITS = SAMPLE_WIDTH - 2;
   localparam int SINE_N = 1 << SINE_TABLE_BITS;
   localparam int EXP_N = 1 << EXP_TABLE_BITS;
   localparam int SINE_ADDR_W = SINE_TABLE_BITS + 1;
   localparam int SINE_VAL_W = FRAC_BITS + 1;
   localparam int MUL_A_W = (SAMPLE_WIDTH > INC_W) ? SAMPLE_WIDTH : INC_W + 1;
   localparam int MUL_B_W = EXP_W + 1;
   localparam int PROD_W = MUL_A_W + MUL_B_W;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

   typedef logic [SINE_VAL_W-1:0] sine_rom_type [0:SINE_N];
   typedef logic [EXP_W-1:0] exp_rom_type [0:EXP_N-1];

   typedef enum logic [3:0] {
      S_IDLE, S_PITCH, S_STEP, S_PHASE, S_SINE, S_MIX1, S_MIX2, S_WAVE, S_OUT, S_DONE
   } state_type;

   function automatic sine_rom_type build_sine();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      longint       s;
      for (int i = 0; i <= SINE_N; i++) begin
         x = (Q30_HALF_PI * 64'(i)) / 64'(SINE_N);
         x2 = (x * x) >> Q30_BITS;
         t = x;
         s = longint'(x);
         for (int k = 1; k <= SINE_TERMS; k++) begin
            t = ((t * x2) >> Q30_BITS) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) begin
            s = 0;
         end
         s = (s * (longint'(1) << FRAC_BITS) + (longint'(1) << (Q30_BITS - 1))) >>> Q30_BITS;
         if (s > (longint'(1) << FRAC_BITS)) begin
            s = longint'(1) << FRAC_BITS;
         end
         rom[i] = SINE_VAL_W'(s);
      end
      return rom;
   endfunction

   function automatic exp_rom_type build_exp();
      exp_rom_type rom;
      logic [63:0] y;
      logic [63:0] t;
      logic [63:0] s;
      for (int i = 0; i < EXP_N; i++) begin
         y = (Q30_LN2 * 64'(i)) / 64'(EXP_N);
         t = Q30_ONE;
         s = Q30_ONE;
         for (int k = 1; k <= EXP_TERMS; k++) begin
            t = ((t * y) >> Q30_BITS) / 64'(k);
            s = s + t;
         end
         rom[i] = EXP_W'(s);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();
   localparam exp_rom_type EXP_ROM = build_exp();

   state_type                    state_ff;
   logic                         rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                         source_mode_ff;
   logic [MIX_W-1:0]             shape_mix_ff;
   logic signed [OFFSET_W-1:0]   pitch_offset_ff;
   logic [INC_W-1:0]             base_inc_ff;
   logic [PHASE_W-1:0]           osc_phase_ff;

   logic signed [SAMPLE_WIDTH-1:0] carrier_ff;
   logic signed [SAMPLE_WIDTH-1:0] modulator_ff;
   logic signed [PITCH_W-1:0]    cv_ff;
   logic [SHIFT_W-1:0]           shift_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [PROD_W-1:0]     acc_ff;
   logic signed [SAMPLE_WIDTH-1:0] m_ff;
   logic [EXP_W-1:0]             exp_data_ff;
   logic [SINE_VAL_W-1:0]        sine_data_ff;

   logic signed [PITCH_W:0]      pitch_sum;
   logic signed [PITCH_W:0]      pitch_clamp;
   logic [PITCH_U_W-1:0]         pitch_u;
   logic [SHIFT_W-1:0]           shift_in;
   logic [EXP_TABLE_BITS-1:0]    exp_addr;
   logic [SINE_TABLE_BITS-1:0]   sine_k;
   logic [SINE_ADDR_W-1:0]       sine_addr;
   logic signed [SAMPLE_WIDTH-1:0] sine_signed;
   logic signed [FRAC_BITS:0]    saw;
   logic [MIX_W-1:0]             mix_clamped;
   logic [PROD_W-1:0]            step_full;
   logic signed [PROD_W-1:0]     wave_sum;
   logic signed [PROD_W-1:0]     wave_full;
   logic signed [PROD_W-1:0]     scaled;
   logic signed [PROD_W-1:0]     saturated;
   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     mul_p;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      pitch_sum = (PITCH_W + 1)'(pitch_offset_ff) + (PITCH_W + 1)'(cv_ff);
      if (pitch_sum > PITCH_LIMIT) begin
         pitch_clamp = PITCH_LIMIT;
      end else if (pitch_sum < PITCH_FLOOR) begin
         pitch_clamp = PITCH_FLOOR;
      end else begin
         pitch_clamp = pitch_sum;
      end
      pitch_u = PITCH_U_W'(pitch_clamp + PITCH_LIMIT);
      shift_in = SHIFT_W'(STEP_SHIFT_TOP) -
                 SHIFT_W'(pitch_u[PITCH_U_W-1:PITCH_FRAC_BITS]);
      exp_addr = pitch_u[PITCH_FRAC_BITS-1 -: EXP_TABLE_BITS];
   end

   always_comb begin
      sine_k = osc_phase_ff[PHASE_W-3 -: SINE_TABLE_BITS];
      if (osc_phase_ff[PHASE_W-2]) begin
         sine_addr = SINE_ADDR_W'(SINE_N) - SINE_ADDR_W'(sine_k);
      end else begin
         sine_addr = SINE_ADDR_W'(sine_k);
      end
      if (osc_phase_ff[PHASE_W-1]) begin
         sine_signed = -$signed(SAMPLE_WIDTH'(sine_data_ff));
      end else begin
         sine_signed = $signed(SAMPLE_WIDTH'(sine_data_ff));
      end
      saw = $signed({~osc_phase_ff[PHASE_W-1], osc_phase_ff[PHASE_W-2 -: FRAC_BITS]});
      mix_clamped = (shape_mix_ff > MIX_FULL) ? MIX_FULL : shape_mix_ff;
   end

   always_comb begin
      step_full = $unsigned(prod_ff) >> shift_ff;
      wave_sum = acc_ff + prod_ff;
      wave_full = wave_sum >>> MIX_FRAC_BITS;
      scaled = (prod_ff + ROUND_BIAS) >>> FRAC_BITS;
      if (scaled > SAT_MAX) begin
         saturated = SAT_MAX;
      end else if (scaled < SAT_MIN) begin
         saturated = SAT_MIN;
      end else begin
         saturated = scaled;
      end
   end

   // The one multiplier; its operands are chosen by the sequencer state.
   always_comb begin
      case (state_ff)
         S_STEP: begin
            mul_a = MUL_A_W'(base_inc_ff);
            mul_b = MUL_B_W'(exp_data_ff);
         end
         S_MIX1: begin
            mul_a = MUL_A_W'(MIX_FULL - mix_clamped);
            mul_b = MUL_B_W'(sine_signed);
         end
         S_MIX2: begin
            mul_a = MUL_A_W'(mix_clamped);
            mul_b = MUL_B_W'(saw);
         end
         S_OUT: begin
            mul_a = MUL_A_W'(carrier_ff);
            mul_b = MUL_B_W'(m_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      exp_data_ff <= EXP_ROM[exp_addr];
      sine_data_ff <= SINE_ROM[sine_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         source_mode_ff <= 1'b0;
         shape_mix_ff <= '0;
         pitch_offset_ff <= '0;
         base_inc_ff <= BASE_INC_RESET;
         osc_phase_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_SOURCE_MODE:    source_mode_ff <= csr_wdata[0];
               CSR_SHAPE_MIX:      shape_mix_ff <= csr_wdata[MIX_W-1:0];
               CSR_PITCH_OFFSET:   pitch_offset_ff <= $signed(csr_wdata[OFFSET_W-1:0]);
               CSR_BASE_INCREMENT: base_inc_ff <= csr_wdata[INC_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  carrier_ff <= req_carrier_sample;
                  modulator_ff <= req_modulator_sample;
                  cv_ff <= req_pitch_cv;
                  state_ff <= S_PITCH;
               end
            end
            S_PITCH: begin
               shift_ff <= shift_in;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               prod_ff <= mul_p;
               state_ff <= S_PHASE;
            end
            S_PHASE: begin
               osc_phase_ff <= osc_phase_ff + step_full[PHASE_W-1:0];
               state_ff <= S_SINE;
            end
            S_SINE: begin
               state_ff <= S_MIX1;
            end
            S_MIX1: begin
               prod_ff <= mul_p;
               state_ff <= S_MIX2;
            end
            S_MIX2: begin
               acc_ff <= prod_ff;
               prod_ff <= mul_p;
               state_ff <= S_WAVE;
            end
            S_WAVE: begin
               m_ff <= source_mode_ff ? modulator_ff : SAMPLE_WIDTH'(wave_full);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               prod_ff <= mul_p;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_sample_ff <= SAMPLE_WIDTH'(saturated);
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PITCH)
      else $error("accepted item did not start the sequence");

   a_phase_only_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_PHASE |=> $stable(osc_phase_ff))
      else $error("oscillator phase moved outside its update step");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the final step");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready |=> state_ff == S_DONE)
      else $error("pending result overwritten");

endmodule

### dv/tb_ring_modulator_with_oscillator_unit.sv
module tb_ring_modulator_with_oscillator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rmod_pkg::*;

   localparam int SINE_BITS = 10;
   localparam int EXP_BITS = 8;
   localparam int SAMPLE_W = 16;
   localparam int FRAC = SAMPLE_W - 2;
   localparam int SINE_N = 1 << SINE_BITS;
   localparam int EXP_N = 1 << EXP_BITS;
   localparam int DRAIN_CYCLES = 30;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int RANDOM_PHASES = 8;
   localparam int FRAMES_PER_PHASE = 55;
   localparam int REPORT_LIMIT = 10;
   localparam int FIRST_UNMAPPED_CSR = int'(CSR_BASE_INCREMENT) + 1;
   localparam int LAST_CSR_INDEX = (1 << CSR_INDEX_W) - 1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] carrier;
      logic signed [SAMPLE_W-1:0] modulator;
      logic signed [PITCH_W-1:0]  pitch_cv;
   } audio_frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_carrier_sample = '0;
   logic signed [SAMPLE_W-1:0] req_modulator_sample = '0;
   logic signed [PITCH_W-1:0] req_pitch_cv = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   audio_frame_type pending_frames[$];
   logic signed [SAMPLE_W-1:0] expected_samples[$];

   longint sine_quarter[0:SINE_N];
   longint unsigned exp2_frac[0:EXP_N-1];

   logic [PHASE_W-1:0] phase_acc = '0;
   logic cfg_source_ext = 1'b0;
   logic [MIX_W-1:0] cfg_shape_mix = '0;
   logic signed [OFFSET_W-1:0] cfg_pitch_offset = '0;
   logic [INC_W-1:0] cfg_base_inc = BASE_INC_RESET;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic rsp_hold = 1'b0;
   logic stall_armed = 1'b0;
   int error_count = 0;
   int reported = 0;
   int frames_accepted = 0;
   int samples_checked = 0;
   int csr_writes = 0;

   ring_modulator_with_oscillator_unit #(
      .SINE_TABLE_BITS(SINE_BITS),
      .EXP_TABLE_BITS(EXP_BITS),
      .SAMPLE_WIDTH(SAMPLE_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_carrier_sample(req_carrier_sample),
      .req_modulator_sample(req_modulator_sample),
      .req_pitch_cv(req_pitch_cv),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_sample(rsp_out_sample),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : table_fill
      longint unsigned x, x2, t, su;
      longint s;
      for (int i = 0; i <= SINE_N; i++) begin
         x = (Q30_HALF_PI * longint'(i)) / longint'(SINE_N);
         x2 = (x * x) >> Q30_BITS;
         t = x;
         s = longint'(x);
         for (int k = 1; k <= SINE_TERMS; k++) begin
            t = ((t * x2) >> Q30_BITS) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) s = 0;
         s = (s * (longint'(1) << FRAC) + (longint'(1) << (Q30_BITS - 1))) >>> Q30_BITS;
         if (s > (longint'(1) << FRAC)) s = longint'(1) << FRAC;
         sine_quarter[i] = s;
      end
      for (int i = 0; i < EXP_N; i++) begin
         x = (Q30_LN2 * longint'(i)) / longint'(EXP_N);
         t = Q30_ONE;
         su = Q30_ONE;
         for (int k = 1; k <= EXP_TERMS; k++) begin
            t = ((t * x) >> Q30_BITS) / longint'(k);
            su = su + t;
         end
         exp2_frac[i] = su;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] predict_sample(audio_frame_type fr);
      longint p, sine, saw, mix, m, prod;
      longint unsigned step;
      int u, n, f, idx, k;
      logic [1:0] quad;
      p = longint'(cfg_pitch_offset) + longint'(fr.pitch_cv);
      if (p > longint'(PITCH_LIMIT)) p = longint'(PITCH_LIMIT);
      if (p < longint'(PITCH_FLOOR)) p = longint'(PITCH_FLOOR);
      u = int'(p - longint'(PITCH_FLOOR));
      n = (u >> PITCH_FRAC_BITS) - 4;
      f = u & ((1 << PITCH_FRAC_BITS) - 1);
      idx = (f >> (PITCH_FRAC_BITS - EXP_BITS)) & (EXP_N - 1);
      step = (longint'(cfg_base_inc) * exp2_frac[idx]) >> (Q30_BITS - n);
      phase_acc = phase_acc + step[PHASE_W-1:0];
      quad = phase_acc[PHASE_W-1:PHASE_W-2];
      k = int'((phase_acc >> (PHASE_W - 2 - SINE_BITS)) & (SINE_N - 1));
      sine = quad[0] ? sine_quarter[SINE_N - k] : sine_quarter[k];
      if (quad[1]) sine = -sine;
      saw = longint'(phase_acc >> (PHASE_W - 1 - FRAC)) - (longint'(1) << FRAC);
      mix = (cfg_shape_mix > MIX_FULL) ? longint'(MIX_FULL) : longint'(cfg_shape_mix);
      if (cfg_source_ext) begin
         m = longint'(fr.modulator);
      end else begin
         m = ((longint'(MIX_FULL) - mix) * sine + mix * saw) >>> MIX_FRAC_BITS;
      end
      prod = (longint'(fr.carrier) * m + (longint'(1) << (FRAC - 1))) >>> FRAC;
      if (prod > (longint'(1) << (SAMPLE_W - 1)) - 1) prod = (longint'(1) << (SAMPLE_W - 1)) - 1;
      if (prod < -(longint'(1) << (SAMPLE_W - 1))) prod = -(longint'(1) << (SAMPLE_W - 1));
      return prod[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_samples.push_back(predict_sample(pending_frames.pop_front()));
            frames_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_carrier_sample <= pending_frames[0].carrier;
               req_modulator_sample <= pending_frames[0].modulator;
               req_pitch_cv <= pending_frames[0].pitch_cv;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : sample_monitor
      logic signed [SAMPLE_W-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            samples_checked++;
            if (expected_samples.size() == 0) begin
               error_count++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("unexpected output sample %0d at %0t", rsp_out_sample, $realtime);
               end
            end else begin
               want = expected_samples.pop_front();
               if (rsp_out_sample !== want) begin
                  error_count++;
                  if (reported < REPORT_LIMIT) begin
                     reported++;
                     $display("out_sample mismatch: expected %0d, got %0d at %0t",
                              want, rsp_out_sample, $realtime);
                  end
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : long_stall
      wait (stall_armed);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_STALL_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #5_000_000;
      $display("tb_ring_modulator_with_oscillator_unit: done, errors");
      $finish;
   end

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_SOURCE_MODE:    cfg_source_ext = data[0];
         CSR_SHAPE_MIX:      cfg_shape_mix = data[MIX_W-1:0];
         CSR_PITCH_OFFSET:   cfg_pitch_offset = data[OFFSET_W-1:0];
         CSR_BASE_INCREMENT: cfg_base_inc = data[INC_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_frames.size() != 0 || expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic queue_frame(int c, int m, int cv);
      audio_frame_type fr;
      fr.carrier = SAMPLE_W'(c);
      fr.modulator = SAMPLE_W'(m);
      fr.pitch_cv = PITCH_W'(cv);
      pending_frames.push_back(fr);
   endtask

   task automatic pick_settings();
      logic [CSR_DATA_W-1:0] data;
      int roll;
      data = $urandom;
      data[0] = ($urandom_range(99) < 35);
      csr_write(CSR_SOURCE_MODE, data);
      data = $urandom;
      roll = $urandom_range(9);
      data[MIX_W-1:0] = MIX_W'((roll == 0) ? 0 : (roll == 1) ? int'(MIX_FULL) :
                        (roll == 2) ? $urandom_range(8191, int'(MIX_FULL) + 1) :
                        $urandom_range(int'(MIX_FULL)));
      csr_write(CSR_SHAPE_MIX, data);
      data = $urandom;
      if ($urandom_range(9) >= 2) begin
         data[OFFSET_W-1:0] = OFFSET_W'($urandom_range(8192) - 4096);
      end
      csr_write(CSR_PITCH_OFFSET, data);
      data = $urandom;
      roll = $urandom_range(9);
      data[INC_W-1:0] = INC_W'((roll == 0) ? 0 : (roll == 1) ? {INC_W{1'b1}} :
                        (roll == 2) ? $urandom_range(1000, 1) : data[INC_W-1:0]);
      csr_write(CSR_BASE_INCREMENT, data);
      if ($urandom_range(3) == 0) begin
         csr_write(CSR_INDEX_W'($urandom_range(LAST_CSR_INDEX, FIRST_UNMAPPED_CSR)), $urandom);
      end
   endtask

   task automatic queue_random_frame();
      int roll, c, m, cv;
      roll = $urandom_range(9);
      c = (roll == 0) ? 32767 : (roll == 1) ? -32768 : int'($urandom_range(65535)) - 32768;
      roll = $urandom_range(9);
      m = (roll == 0) ? 32767 : (roll == 1) ? -32768 : int'($urandom_range(65535)) - 32768;
      roll = $urandom_range(9);
      cv = (roll < 7) ? int'($urandom_range(16384)) - 8192 : int'($urandom_range(65535)) - 32768;
      queue_frame(c, m, cv);
   endtask

   initial begin : stimulus
      @(negedge reset);

      queue_frame(32767, 0, 0);
      queue_frame(-32768, 32767, 32767);
      queue_frame(16384, -32768, -32768);
      queue_frame(-1, 1, 2048);
      wait_idle();

      csr_write(CSR_SOURCE_MODE, 32'hFFFF_FFFF);
      csr_write(CSR_SHAPE_MIX, {19'h7FFFF, MIX_FULL});
      csr_write(CSR_PITCH_OFFSET, 32'hFFFF_F000);
      csr_write(CSR_BASE_INCREMENT, 32'hFFFF_FFFF);
      queue_frame(-32768, -32768, 0);
      queue_frame(32767, -32768, 0);
      queue_frame(-32768, 32767, 0);
      queue_frame(0, 0, 0);
      queue_frame(16384, 16384, -2048);
      wait_idle();

      csr_write(CSR_SOURCE_MODE, 32'h0000_0000);
      csr_write(CSR_SHAPE_MIX, 32'd8191);
      csr_write(CSR_PITCH_OFFSET, 32'd4096);
      queue_frame(32767, 0, 32767);
      queue_frame(32767, 0, -32768);
      queue_frame(-32768, 0, 0);
      queue_frame(32767, 0, 8191);
      wait_idle();

      csr_write(CSR_BASE_INCREMENT, 32'hF000_0000);
      csr_write(CSR_SHAPE_MIX, 32'd2048);
      csr_write(CSR_PITCH_OFFSET, 32'h0000_3000);
      csr_write(CSR_INDEX_W'(FIRST_UNMAPPED_CSR), 32'hFFFF_FFFF);
      csr_write(CSR_INDEX_W'(LAST_CSR_INDEX), 32'h5A5A_A5A5);
      queue_frame(32767, 0, 0);
      queue_frame(-32768, 0, 0);
      queue_frame(12345, 0, -4096);
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         pick_settings();
         if (ph == 0) stall_armed = 1'b1;
         for (int i = 0; i < FRAMES_PER_PHASE; i++) queue_random_frame();
         wait_idle();
      end

      if (expected_samples.size() != 0) error_count++;
      $display("Covered %0d frames, %0d output samples checked, %0d register writes.",
               frames_accepted, samples_checked, csr_writes);
      $display("Both sources, sine to saw mixes, pitch clamping and four idle patterns were used.");
      if (error_count == 0) begin
         $display("tb_ring_modulator_with_oscillator_unit: done, clean");
      end else begin
         $display("tb_ring_modulator_with_oscillator_unit: done, errors");
      end
      $finish;
   end

endmodule
